/* rtl/pfd_pkg.sv */
`default_nettype none
package pfd_pkg;
   localparam int SAMPLE_WIDTH = 16;
   localparam int PHASE_WIDTH  = 24;
   localparam int CORDIC_STEPS = 32;

   localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
   localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
   localparam logic [2:0] REG_FREQ_LIMIT = 3'd2;
   localparam logic [2:0] REG_DC_COEFF   = 3'd3;
   localparam logic [2:0] REG_OUT_GAIN   = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CORDIC, ST_LOOP, ST_GAIN, ST_DC, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic cordic_step;
      logic loop_update;
      logic gain_step;
      logic dc_update;
      logic out_calc;
   } cmd_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] k);
      logic [31:0] t;
      unique case (k)
         5'd0: t = 32'h20000000;  5'd1: t = 32'h12E4051E;
         5'd2: t = 32'h09FB385B;  5'd3: t = 32'h051111D4;
         5'd4: t = 32'h028B0D43;  5'd5: t = 32'h0145D7E1;
         5'd6: t = 32'h00A2F61E;  5'd7: t = 32'h00517C55;
         5'd8: t = 32'h0028BE53;  5'd9: t = 32'h00145F2F;
         5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
         5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3;
         5'd14: t = 32'h0000A2FA; 5'd15: t = 32'h0000517D;
         5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
         5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518;
         5'd20: t = 32'h0000028C; 5'd21: t = 32'h00000146;
         5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
         5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014;
         5'd26: t = 32'h0000000A; 5'd27: t = 32'h00000005;
         5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
         5'd30: t = 32'h00000001; default: t = 32'h00000000;
      endcase
      return t;
   endfunction
endpackage
`default_nettype wire

/* rtl/pfd_ctrl.sv */
`default_nettype none
module pfd_ctrl import pfd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire logic     cordic_last,
   output cmd_type       cmd
);
   state_type state_ff, state_in;
   logic      out_full_ff, out_full_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         out_full_ff <= out_full_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = (state_ff == ST_IDLE);
      rsp_valid   = out_full_ff;
      out_full_in = out_full_ff;
      if (out_full_ff && rsp_ready) out_full_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (cordic_last) state_in = ST_LOOP;
         end
         ST_LOOP: begin
            cmd.loop_update = 1'b1;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.gain_step = 1'b1;
            state_in = ST_DC;
         end
         ST_DC: begin
            cmd.dc_update = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: if (!out_full_ff || rsp_ready) begin
            // hand result to the output register once it is free
            cmd.out_calc = 1'b1;
            out_full_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == ST_IDLE) else $error("load outside idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_cordic_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CORDIC && cordic_last |=> state_ff == ST_LOOP)
      else $error("cordic exit");
`endif
endmodule
`default_nettype wire

/* rtl/pfd_datapath.sv */
`default_nettype none
module pfd_datapath import pfd_pkg::*; (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire cmd_type                        cmd,
   input  wire logic                           hold_out,
   output logic                                cordic_last,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample_i,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample_q,
   input  wire logic                           csr_valid,
   input  wire logic [2:0]                     csr_index,
   input  wire logic [31:0]                    csr_data,
   output logic signed [15:0]                  rsp_audio
);
   logic [23:0] prop_gain_ff, integ_gain_ff;
   logic [22:0] freq_limit_ff;
   logic [15:0] dc_coeff_ff, out_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= 24'd1048576;
         integ_gain_ff <= 24'd65536;
         freq_limit_ff <= 23'd1048576;
         dc_coeff_ff   <= 16'd64;
         out_gain_ff   <= 16'd256;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_PROP_GAIN:  prop_gain_ff  <= csr_data[23:0];
            REG_INTEG_GAIN: integ_gain_ff <= csr_data[23:0];
            REG_FREQ_LIMIT: freq_limit_ff <= csr_data[22:0];
            REG_DC_COEFF:   dc_coeff_ff   <= csr_data[15:0];
            REG_OUT_GAIN:   out_gain_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // cordic: x grows by up to 1.65x, so 35 bits signed hold it
   logic signed [34:0] x_ff, y_ff;
   logic [31:0] z_ff;
   logic [4:0]  k_ff;
   logic        zero_ff;
   logic signed [34:0] xs, ys, si_ext, sq_ext;

   assign si_ext = 35'(req_sample_i) <<< (32 - SAMPLE_WIDTH);
   assign sq_ext = 35'(req_sample_q) <<< (32 - SAMPLE_WIDTH);
   assign xs = x_ff >>> k_ff;
   assign ys = y_ff >>> k_ff;
   assign cordic_last = (k_ff == 5'(CORDIC_STEPS - 1));

   logic [PHASE_WIDTH-1:0] phase_ff;
   logic signed [23:0] freq_ff;
   logic signed [39:0] dc_ff;
   logic signed [PHASE_WIDTH-1:0] err_ff;
   logic signed [48:0] pprod_ff, iprod;
   logic signed [24:0] fsum;
   // frequency minus DC spans twice the DC range
   logic signed [40:0] diff_ff;
   logic signed [57:0] dprod;
   logic signed [57:0] aprod;
   logic [32:0] zr;
   logic [PHASE_WIDTH-1:0] zsum;

   assign zr   = ({1'b0, z_ff} + 33'(1 << (32 - PHASE_WIDTH - 1))) >> (32 - PHASE_WIDTH);
   assign zsum = zr[PHASE_WIDTH-1:0] + phase_ff;
   assign iprod = 49'(err_ff) * $signed({1'b0, integ_gain_ff});
   assign fsum = 25'(freq_ff) + 25'(iprod >>> 24);
   assign dprod = 58'(diff_ff) * $signed({1'b0, dc_coeff_ff});
   assign aprod = 58'(diff_ff) * $signed({1'b0, out_gain_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         freq_ff  <= '0;
         dc_ff    <= '0;
      end else begin
         if (cmd.loop_update) begin
            if (fsum > $signed({2'b0, freq_limit_ff}))
               freq_ff <= 24'(freq_limit_ff);
            else if (fsum < -$signed({2'b0, freq_limit_ff}))
               freq_ff <= -24'(freq_limit_ff);
            else
               freq_ff <= fsum[23:0];
         end
         if (cmd.gain_step)
            phase_ff <= phase_ff + PHASE_WIDTH'(freq_ff) + PHASE_WIDTH'(pprod_ff >>> 24);
         if (cmd.dc_update)
            dc_ff <= dc_ff + 40'(dprod >>> 16);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         zero_ff <= (req_sample_i == '0) && (req_sample_q == '0);
         k_ff    <= '0;
         if (req_sample_i < 0) begin
            x_ff <= -si_ext;
            y_ff <= -sq_ext;
            z_ff <= 32'h80000000;
         end else begin
            x_ff <= si_ext;
            y_ff <= sq_ext;
            z_ff <= '0;
         end
      end else if (cmd.cordic_step) begin
         k_ff <= k_ff + 5'd1;
         if (y_ff > 0) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + atan_entry(k_ff);
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - atan_entry(k_ff);
         end
         if (cordic_last)
            err_ff <= zero_ff ? '0 : $signed(-zsum);
      end
      if (cmd.loop_update)
         pprod_ff <= 49'(err_ff) * $signed({1'b0, prop_gain_ff});
      if (cmd.gain_step)
         diff_ff <= (41'(freq_ff) <<< 16) - 41'(dc_ff);
      if (cmd.dc_update)
         diff_ff <= (41'(freq_ff) <<< 16) - (41'(dc_ff) + 41'(dprod >>> 16));
      if (cmd.out_calc && !hold_out) begin
         if ((aprod >>> 32) > 58'sd32767) rsp_audio <= 16'sd32767;
         else if ((aprod >>> 32) < -58'sd32768) rsp_audio <= -16'sd32768;
         else rsp_audio <= 16'(aprod >>> 32);
      end
   end
endmodule
`default_nettype wire

/* rtl/pll_fm_demodulator.sv */
// channel  | handshake             | payload
// req      | req_valid/req_ready   | req_sample_i, req_sample_q
// rsp      | rsp_valid/rsp_ready   | rsp_audio
// csr      | csr_valid/csr_ready   | csr_index, csr_data
// One request passes through load, 32 CORDIC steps, loop, gain, DC and output;
// the 32-step CORDIC iteration is the longest part of that sequence.
// Reset is synchronous; it restores register defaults and clears loop state.
// A result waits in the output register while the next request is accepted and processed;
// the output step stalls until that waiting result is taken.
`default_nettype none
module pll_fm_demodulator import pfd_pkg::*; (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample_i,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample_q,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [15:0]                  rsp_audio,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [2:0]                     csr_index,
   input  wire logic [31:0]                    csr_data
);
   cmd_type cmd;
   logic    cordic_last;

   assign csr_ready = 1'b1;

   pfd_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cordic_last, .cmd
   );

   pfd_datapath u_dp (
      .clock, .reset, .cmd, .hold_out(1'b0), .cordic_last,
      .req_sample_i, .req_sample_q, .csr_valid, .csr_index, .csr_data, .rsp_audio
   );
endmodule
`default_nettype wire

/* dv/tb_pll_fm_demodulator.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_pll_fm_demodulator;
   import pfd_pkg::*;

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] si;
      logic signed [SAMPLE_WIDTH-1:0] sq;
   } sample_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SAMPLE_WIDTH-1:0] req_sample_i = '0;
   logic signed [SAMPLE_WIDTH-1:0] req_sample_q = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_audio;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   pll_fm_demodulator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample_i(req_sample_i), .req_sample_q(req_sample_q),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_audio(rsp_audio),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // loop model
   logic [23:0] alpha, beta;
   logic [22:0] flimit;
   logic [15:0] dc_k, gain_q88;
   logic [PHASE_WIDTH-1:0] phase_acc;
   longint freq_acc, dc_acc;

   sample_t pending_samples[$];
   logic signed [15:0] expected_audio[$];
   int errors = 0;
   int checked = 0;
   int saturated = 0;
   longint cycles = 0;
   bit quiet = 1'b0;
   int hold_rsp = 0;
   bit hold_start = 1'b0;
   bit hold_done = 1'b0;
   bit drain_req = 1'b0;

   function automatic longint floor_shift(longint v, int k);
      if (v >= 0) return v >>> k;
      return -((-(v + 1)) >>> k) - 1;
   endfunction

   function automatic logic [31:0] atan_tab(int k);
      logic [31:0] t [32] = '{
         32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
         32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
         32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
         32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
         32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
         32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
         32'h00000001, 32'h00000000};
      return t[k];
   endfunction

   function automatic logic [31:0] vector_angle(longint x, longint y);
      logic [31:0] z = 0;
      longint dx, dy;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h8000_0000;
      end
      for (int k = 0; k < 32; k++) begin
         dx = floor_shift(y, k);
         dy = floor_shift(x, k);
         if (y > 0) begin
            x += dx; y -= dy; z += atan_tab(k);
         end else begin
            x -= dx; y += dy; z -= atan_tab(k);
         end
      end
      return z;
   endfunction

   function automatic logic signed [15:0] demod_sample(sample_t s);
      longint err = 0, f, lim, diff, y;
      logic [32:0] z;
      logic [PHASE_WIDTH-1:0] zp, neg;
      if (s.si != 0 || s.sq != 0) begin
         z = {1'b0, vector_angle(longint'(s.si) <<< 16, longint'(s.sq) <<< 16)};
         z = (z + 33'd128) >> 8;
         zp = z[PHASE_WIDTH-1:0] + phase_acc;
         neg = -zp;
         err = longint'($signed(neg));
      end
      f = freq_acc + floor_shift(longint'(beta) * err, 24);
      lim = longint'(flimit);
      if (f > lim) f = lim;
      else if (f < -lim) f = -lim;
      freq_acc = f;
      phase_acc = phase_acc + f[PHASE_WIDTH-1:0]
                  + PHASE_WIDTH'(floor_shift(longint'(alpha) * err, 24));
      dc_acc += floor_shift(longint'(dc_k) * (f * 65536 - dc_acc), 16);
      diff = f * 65536 - dc_acc;
      y = floor_shift(diff * longint'(gain_q88), 32);
      if (y > 32767) begin y = 32767; saturated++; end
      else if (y < -32768) begin y = -32768; saturated++; end
      return y[15:0];
   endfunction

   function automatic void write_model_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
         REG_PROP_GAIN:  alpha = v[23:0];
         REG_INTEG_GAIN: beta = v[23:0];
         REG_FREQ_LIMIT: flimit = v[22:0];
         REG_DC_COEFF:   dc_k = v[15:0];
         REG_OUT_GAIN:   gain_q88 = v[15:0];
         default: ;
      endcase
   endfunction

   // driver: pull from the pending queue, random gaps
   int gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            sample_t s;
            s.si = req_sample_i;
            s.sq = req_sample_q;
            expected_audio.push_back(demod_sample(s));
         end
         if (gap > 0) begin
            gap <= gap - 1;
            req_valid <= 1'b0;
         end else if (pending_samples.size() > 0 && !drain_req) begin
            req_valid <= 1'b1;
            req_sample_i <= pending_samples[0].si;
            req_sample_q <= pending_samples[0].sq;
            void'(pending_samples.pop_front());
            if (!quiet && $urandom_range(0, 5) == 0) gap <= $urandom_range(1, 5);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold, counted here
   always @(posedge clock) begin
      if (hold_rsp > 0) begin
         hold_rsp <= hold_rsp - 1;
      end else if (hold_start && !hold_done) begin
         hold_rsp  <= 300;
         hold_done <= 1'b1;
      end
   end

   // monitor and receiver stall
   int stall = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_audio.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response audio=%0d", rsp_audio);
            end else begin
               if (rsp_audio !== expected_audio[0]) begin
                  errors++;
                  if (errors <= 10)
                     $display("audio mismatch: expected %0d got %0d",
                              expected_audio[0], rsp_audio);
               end
               void'(expected_audio.pop_front());
               checked++;
            end
         end
         if (hold_rsp > 0) begin
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall <= stall - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall <= $urandom_range(0, 4);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > 400000) begin
         $display("timeout with %0d responses outstanding", expected_audio.size());
         $display("tb_pll_fm_demodulator: FAIL");
         $finish;
      end
   end

   function automatic logic signed [15:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return '0;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic queue_sample(logic signed [15:0] i, logic signed [15:0] q);
      sample_t s;
      s.si = i;
      s.sq = q;
      pending_samples.push_back(s);
   endtask

   // wait for everything to drain, plus the block's latency
   task automatic wait_idle();
      while (pending_samples.size() > 0 || req_valid || expected_audio.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      write_model_reg(idx, v);
      @(posedge clock);
   endtask

   // tone at a given phase step, with slight amplitude noise
   task automatic queue_tone(int n, int step, int amp);
      real ph = $urandom_range(0, 6283) / 1000.0;
      for (int k = 0; k < n; k++) begin
         ph += step * 6.283185307 / 65536.0;
         queue_sample(16'($rtoi(amp * $cos(ph)) + $urandom_range(0, 8) - 4),
                      16'($rtoi(amp * $sin(ph)) + $urandom_range(0, 8) - 4));
      end
   endtask

   task automatic random_config();
      write_reg(REG_PROP_GAIN, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 4000000));
      write_reg(REG_INTEG_GAIN, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 400000));
      write_reg(REG_FREQ_LIMIT, $urandom());
      write_reg(REG_DC_COEFF, $urandom());
      write_reg(REG_OUT_GAIN, $urandom());
   endtask

   initial begin
      alpha = 24'd1048576; beta = 24'd65536; flimit = 23'd1048576;
      dc_k = 16'd64; gain_q88 = 16'd256;
      phase_acc = '0; freq_acc = 0; dc_acc = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero vector, axes
      queue_sample(0, 0);
      queue_sample(16'sh7FFF, 0);
      queue_sample(16'sh8000, 0);
      queue_sample(0, 16'sh7FFF);
      queue_sample(0, 16'sh8000);
      queue_sample(16'sh8000, 16'sh8000);
      queue_sample(16'sh7FFF, 16'sh7FFF);
      queue_sample(16'sh8000, 16'sh7FFF);
      queue_sample(16'sh7FFF, 16'sh8000);
      queue_sample(-1, -1);
      queue_sample(1, 0);
      queue_sample(0, 0);
      wait_idle();

      // pinned frequency, large gain to force saturation, unknown index ignored
      write_reg(REG_FREQ_LIMIT, 32'h0);
      write_reg(3'd5, 32'hFFFF_FFFF);
      write_reg(3'd7, 32'h1234_5678);
      for (int k = 0; k < 6; k++) queue_sample(rand_field(), rand_field());
      wait_idle();
      write_reg(REG_FREQ_LIMIT, 32'hFFFF_FFFF);
      write_reg(REG_PROP_GAIN, 32'hFFFF_FFFF);
      write_reg(REG_INTEG_GAIN, 32'hFFFF_FFFF);
      write_reg(REG_DC_COEFF, 32'h0);
      write_reg(REG_OUT_GAIN, 32'hFFFF_FFFF);
      for (int k = 0; k < 6; k++) queue_sample(rand_field(), rand_field());
      wait_idle();

      // random phases: tones and random samples, random config except for a fixed last phase
      for (int p = 0; p < 12; p++) begin
         if (p == 11) begin
            write_reg(REG_PROP_GAIN, 0); write_reg(REG_INTEG_GAIN, 0);
            write_reg(REG_DC_COEFF, 32'hFFFF); write_reg(REG_OUT_GAIN, 0);
         end else begin
            random_config();
         end
         for (int b = 0; b < 6; b++) begin
            if ($urandom_range(0, 3) == 0)
               for (int k = 0; k < 8; k++) queue_sample(rand_field(), rand_field());
            else
               queue_tone($urandom_range(10, 40), $urandom_range(0, 4000) - 2000,
                          $urandom_range(100, 32000));
         end
         if (p == 4) begin
            // long receiver hold while the sender keeps offering
            hold_start = 1'b1;
         end
         if (p == 7) begin
            // sender pauses mid-stream until everything is back
            repeat (200) @(posedge clock);
            drain_req = 1'b1;
            while (expected_audio.size() > 0 || req_valid) @(posedge clock);
            drain_req = 1'b0;
         end
         wait_idle();
      end

      // final part without idling
      quiet = 1'b1;
      random_config();
      queue_tone(100, 700, 20000);
      wait_idle();

      $display("covered %0d samples over extreme and random loop settings, %0d saturated",
               checked, saturated);
      if (errors == 0 && expected_audio.size() == 0)
         $display("tb_pll_fm_demodulator: PASS");
      else
         $display("tb_pll_fm_demodulator: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
